[rtl/ptb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptb_pkg - shared types and constants of the page table builder
// Entry layout, status codes and the shared adder interface.
// ----------------------------------------------------------------------------
package ptb_pkg;

	localparam int unsigned TABLE_SLOTS_DEF = 64;
	localparam int unsigned ENTRIES         = 512;
	localparam int unsigned IDX_W           = 9;
	localparam int unsigned FRAME_W         = 40;
	localparam int unsigned ENTRY_W         = 64;
	localparam int unsigned LARGE_W         = 31;   // phys bits 51..21
	localparam int unsigned STATUS_W        = 2;

	// low flag bits of an entry: present, writable, large page
	localparam logic [11:0] FLAGS_DIR  = 12'h003;
	localparam logic [11:0] FLAGS_LEAF = 12'h083;

	localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
	localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd1;
	localparam logic [STATUS_W-1:0] ST_OUTSIDE   = 2'd2;

	typedef enum logic {
		ALU_ADD,
		ALU_SUB
	} alu_op_t;

	typedef struct packed {
		logic [FRAME_W-1:0] sum;
		logic               ge;    // sum >= limit
	} alu_res_t;

	// directory entry pointing at a table frame
	function automatic logic [ENTRY_W-1:0] make_dir_entry(input logic [FRAME_W-1:0] frame);
		make_dir_entry = {12'h000, frame, FLAGS_DIR};
	endfunction

	// 2 MiB leaf entry
	function automatic logic [ENTRY_W-1:0] make_leaf(input logic [LARGE_W-1:0] phys_hi);
		make_leaf = {12'h000, phys_hi, 9'h000, FLAGS_LEAF};
	endfunction

endpackage

[rtl/ptb_table_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptb_table_mem - table store
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ptb_table_mem import ptb_pkg::*; #(
	parameter int unsigned DEPTH  = TABLE_SLOTS_DEF * ENTRIES,
	parameter int unsigned ADDR_W = $clog2(DEPTH)
) (
	input  logic               clk,
	input  logic               we,
	input  logic [ADDR_W-1:0]  waddr,
	input  logic [ENTRY_W-1:0] wdata,
	input  logic [ADDR_W-1:0]  raddr,
	output logic [ENTRY_W-1:0] rdata
);

	logic [ENTRY_W-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

[rtl/ptb_addsub.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ptb_addsub - shared frame adder
// Adds or subtracts two frame numbers and compares the result to a limit.
// ----------------------------------------------------------------------------
module ptb_addsub import ptb_pkg::*; (
	input  alu_op_t            op,
	input  logic [FRAME_W-1:0] a,
	input  logic [FRAME_W-1:0] b,
	input  logic [FRAME_W-1:0] limit,
	output alu_res_t           res
);

	logic [FRAME_W-1:0] sum;

	always_comb begin
		unique case (op)
			ALU_ADD: sum = a + b;
			ALU_SUB: sum = a - b;
			default: sum = a + b;
		endcase
		res.sum = sum;
		res.ge  = (sum >= limit);
	end

endmodule

[rtl/page_table_builder_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_table_builder_unit - 2 MiB page table builder
// Walks root and second-level tables, allocates missing tables from a bump
// pool, writes large-page leaves, and serves single-entry reads.
// ----------------------------------------------------------------------------
//
//  Channel | Handshake             | Payload
//  --------+-----------------------+-----------------------------------------
//  cfg     | cfg_valid / cfg_ready | table_base_frame
//  in      | in_valid / in_ready   | kind, virt_addr, phys_addr, read_slot,
//          |                       | read_entry
//  out     | out_valid / out_ready | status, read_data, tables_used,
//          |                       | new_tables
//
// A map transfer steps through read, evaluate, read, evaluate and leaf write
// before the result is valid, with fewer steps if it ends early; a read transfer
// steps through read issue and read data. The reads share the store's single read port.
// One item at a time: in_ready is low until the result transfer completes.
// After reset the store is swept to zero, one entry per cycle, over all
// TABLE_SLOTS * 512 entries; in_ready stays low meanwhile. cfg_ready is
// always high; configuration writes land at any time.
// ----------------------------------------------------------------------------
module page_table_builder_unit import ptb_pkg::*; #(
	parameter int unsigned TABLE_SLOTS = TABLE_SLOTS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	// configuration
	input  logic                cfg_valid,
	output logic                cfg_ready,
	input  logic [FRAME_W-1:0]  table_base_frame,
	// request
	input  logic                in_valid,
	output logic                in_ready,
	input  logic                kind,
	input  logic [47:0]         virt_addr,
	input  logic [51:0]         phys_addr,
	input  logic [5:0]          read_slot,
	input  logic [IDX_W-1:0]    read_entry,
	// result
	output logic                out_valid,
	input  logic                out_ready,
	output logic [STATUS_W-1:0] status,
	output logic [ENTRY_W-1:0]  read_data,
	output logic [6:0]          tables_used,
	output logic [1:0]          new_tables
);

	localparam int unsigned SLOT_W = $clog2(TABLE_SLOTS);
	localparam int unsigned CNT_W  = $clog2(TABLE_SLOTS + 1);
	localparam int unsigned ADDR_W = SLOT_W + IDX_W;
	localparam int unsigned DEPTH  = TABLE_SLOTS * ENTRIES;

	// sequencer states
	localparam logic [3:0] S_CLEAR    = 4'd0;
	localparam logic [3:0] S_IDLE     = 4'd1;
	localparam logic [3:0] S_RD_ISSUE = 4'd2;
	localparam logic [3:0] S_RD_DATA  = 4'd3;
	localparam logic [3:0] S_ISSUE4   = 4'd4;
	localparam logic [3:0] S_EVAL4    = 4'd5;
	localparam logic [3:0] S_ISSUE3   = 4'd6;
	localparam logic [3:0] S_EVAL3    = 4'd7;
	localparam logic [3:0] S_LEAF     = 4'd8;
	localparam logic [3:0] S_OUT      = 4'd9;

	logic [3:0]         state_q;
	logic [ADDR_W-1:0]  clr_q;
	logic [CNT_W-1:0]   nfs_q;       // next free pool slot
	logic [FRAME_W-1:0] base_q;

	// item registers
	logic               kind_q;
	logic [IDX_W-1:0]   i4_q, i3_q, i2_q;
	logic [LARGE_W-1:0] phys_hi_q;
	logic [SLOT_W-1:0]  rslot_q;
	logic               rslot_ok_q;
	logic [IDX_W-1:0]   rent_q;
	logic [SLOT_W-1:0]  child_q;

	// result registers
	logic [STATUS_W-1:0] status_q;
	logic [ENTRY_W-1:0]  data_q;
	logic [1:0]          made_q;

	// store port
	logic               mem_we;
	logic [ADDR_W-1:0]  mem_waddr, mem_raddr, eval_addr;
	logic [ENTRY_W-1:0] mem_wdata, mem_rdata;

	// shared adder
	alu_op_t            alu_op;
	logic [FRAME_W-1:0] alu_a, alu_b, alu_lim;
	alu_res_t           alu_res;

	logic               present;
	logic               pool_full;
	logic               accept;
	logic [CNT_W-1:0]   nfs_m1;
	logic [SLOT_W-1:0]  ptr_child;
	logic [SLOT_W-1:0]  alloc_child;

	assign cfg_ready   = 1'b1;
	assign in_ready    = (state_q == S_IDLE);
	assign accept      = in_valid && in_ready;
	assign out_valid   = (state_q == S_OUT);
	assign status      = status_q;
	assign read_data   = data_q;
	assign new_tables  = made_q;
	assign tables_used = 7'({{7{1'b0}}, nfs_q});

	// entry being evaluated: present bit decides follow or allocate
	assign present     = mem_rdata[0];
	assign pool_full   = (nfs_q == CNT_W'(TABLE_SLOTS));
	assign nfs_m1      = nfs_q - CNT_W'(1);
	assign alloc_child = nfs_q[SLOT_W-1:0];
	assign ptr_child   = alu_res.sum[SLOT_W-1:0] + SLOT_W'(1);

	// follow: offset = frame - base, outside pool if offset >= next_free - 1
	// allocate: frame = base + next_free - 1
	always_comb begin
		alu_op  = present ? ALU_SUB : ALU_ADD;
		alu_a   = present ? mem_rdata[51:12] : base_q;
		alu_b   = present ? base_q : FRAME_W'({{FRAME_W{1'b0}}, nfs_m1});
		alu_lim = FRAME_W'({{FRAME_W{1'b0}}, nfs_m1});
	end

	ptb_addsub u_addsub (
		.op    (alu_op),
		.a     (alu_a),
		.b     (alu_b),
		.limit (alu_lim),
		.res   (alu_res)
	);

	always_comb begin
		eval_addr = (state_q == S_EVAL4) ? {{SLOT_W{1'b0}}, i4_q} : {child_q, i3_q};

		mem_we    = 1'b0;
		mem_waddr = eval_addr;
		mem_wdata = make_dir_entry(alu_res.sum);
		unique case (state_q)
			S_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				mem_wdata = '0;
			end
			S_EVAL4, S_EVAL3: begin
				mem_we = !present && !pool_full;
			end
			S_LEAF: begin
				mem_we    = 1'b1;
				mem_waddr = {child_q, i2_q};
				mem_wdata = make_leaf(phys_hi_q);
			end
			default: begin
				mem_we = 1'b0;
			end
		endcase

		unique case (state_q)
			S_ISSUE4: mem_raddr = {{SLOT_W{1'b0}}, i4_q};
			S_ISSUE3: mem_raddr = {child_q, i3_q};
			default:  mem_raddr = {rslot_q, rent_q};
		endcase
	end

	ptb_table_mem #(
		.DEPTH  (DEPTH),
		.ADDR_W (ADDR_W)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (mem_waddr),
		.wdata (mem_wdata),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			nfs_q   <= CNT_W'(1);
			base_q  <= '0;
		end else begin
			if (cfg_valid) begin
				base_q <= table_base_frame;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + ADDR_W'(1);
					if (clr_q == ADDR_W'(DEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						state_q <= kind ? S_RD_ISSUE : S_ISSUE4;
					end
				end
				S_RD_ISSUE: state_q <= S_RD_DATA;
				S_RD_DATA:  state_q <= S_OUT;
				S_ISSUE4:   state_q <= S_EVAL4;
				S_ISSUE3:   state_q <= S_EVAL3;
				S_EVAL4, S_EVAL3: begin
					if (!present) begin
						if (pool_full) begin
							state_q <= S_OUT;
						end else begin
							nfs_q   <= nfs_q + CNT_W'(1);
							state_q <= (state_q == S_EVAL4) ? S_ISSUE3 : S_LEAF;
						end
					end else if (alu_res.ge) begin
						state_q <= S_OUT;
					end else begin
						state_q <= (state_q == S_EVAL4) ? S_ISSUE3 : S_LEAF;
					end
				end
				S_LEAF: state_q <= S_OUT;
				S_OUT: begin
					if (out_ready) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// item and result payload
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q     <= kind;
			i4_q       <= virt_addr[47:39];
			i3_q       <= virt_addr[38:30];
			i2_q       <= virt_addr[29:21];
			phys_hi_q  <= phys_addr[51:21];
			rslot_q    <= SLOT_W'({{SLOT_W{1'b0}}, read_slot});
			rslot_ok_q <= (int'(read_slot) < TABLE_SLOTS);
			rent_q     <= read_entry;
			made_q     <= '0;
			status_q   <= ST_DONE;
			data_q     <= '0;
		end
		if (state_q == S_RD_DATA) begin
			data_q <= rslot_ok_q ? mem_rdata : '0;
		end
		if (!kind_q && (state_q == S_EVAL4 || state_q == S_EVAL3)) begin
			if (!present) begin
				if (pool_full) begin
					status_q <= ST_EXHAUSTED;
				end else begin
					child_q <= alloc_child;
					made_q  <= made_q + 2'd1;
				end
			end else if (alu_res.ge) begin
				status_q <= ST_OUTSIDE;
			end else begin
				child_q <= ptr_child;
			end
		end
		if (state_q == S_LEAF) begin
			data_q <= make_leaf(phys_hi_q);
		end
	end

endmodule

[sim/page_table_builder_unit_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// page_table_builder_unit_test - self-checking bench for the page table builder
// Drives map and read requests and checks every result against a local walk
// model. The model keeps its own copy of the tables, the pool counter and the
// base frame. Covers pool exhaustion, stale pointers after base changes, and
// random stalls on both sides.
// ----------------------------------------------------------------------------
module page_table_builder_unit_test import ptb_pkg::*; ();

	localparam int unsigned SLOTS      = TABLE_SLOTS_DEF;
	localparam int unsigned IDLE_LIMIT = 100000;   // covers the post-reset sweep
	localparam int unsigned PHASE_ITEMS = 262;
	localparam int unsigned REPORT_CAP  = 50;

	// request kinds
	localparam logic KIND_MAP  = 1'b0;
	localparam logic KIND_READ = 1'b1;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_valid = 1'b0;
	logic                cfg_ready;
	logic [FRAME_W-1:0]  table_base_frame = '0;
	logic                in_valid = 1'b0;
	logic                in_ready;
	logic                kind = KIND_MAP;
	logic [47:0]         virt_addr = '0;
	logic [51:0]         phys_addr = '0;
	logic [5:0]          read_slot = '0;
	logic [IDX_W-1:0]    read_entry = '0;
	logic                out_valid;
	logic                out_ready = 1'b0;
	logic [STATUS_W-1:0] status;
	logic [ENTRY_W-1:0]  read_data;
	logic [6:0]          tables_used;
	logic [1:0]          new_tables;

	always #1 clk = ~clk;

	page_table_builder_unit #(
		.TABLE_SLOTS(SLOTS)
	) u_dut (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_valid        (cfg_valid),
		.cfg_ready        (cfg_ready),
		.table_base_frame (table_base_frame),
		.in_valid         (in_valid),
		.in_ready         (in_ready),
		.kind             (kind),
		.virt_addr        (virt_addr),
		.phys_addr        (phys_addr),
		.read_slot        (read_slot),
		.read_entry       (read_entry),
		.out_valid        (out_valid),
		.out_ready        (out_ready),
		.status           (status),
		.read_data        (read_data),
		.tables_used      (tables_used),
		.new_tables       (new_tables)
	);

	typedef struct {
		logic [STATUS_W-1:0] status;
		logic [ENTRY_W-1:0]  data;
		logic [6:0]          used;
		logic [1:0]          made;
	} walk_result_t;

	// ------------------------------------------------------------------------
	// Walk model and result queue. Unwritten entries read as zero, matching
	// the cleared store after reset.
	// ------------------------------------------------------------------------
	class page_walk_scoreboard;
		logic [ENTRY_W-1:0] store [int unsigned];
		int unsigned        next_slot;
		logic [FRAME_W-1:0] base;
		walk_result_t       pending_q [$];
		int unsigned        written [$];   // positions ever written, for reads
		int unsigned        fails;
		int unsigned        n_checked;
		int unsigned        n_maps;
		int unsigned        n_reads;
		int unsigned        st_count [3];

		function new();
			next_slot = 1;
			base = '0;
			fails = 0;
			n_checked = 0;
			n_maps = 0;
			n_reads = 0;
			st_count = '{0, 0, 0};
		endfunction

		function logic [ENTRY_W-1:0] entry_at(int unsigned pos);
			return store.exists(pos) ? store[pos] : '0;
		endfunction

		function void put_entry(int unsigned pos, logic [ENTRY_W-1:0] val);
			store[pos] = val;
			written.push_back(pos);
		endfunction

		function void set_base(logic [FRAME_W-1:0] val);
			base = val;
		endfunction

		function int unsigned pending();
			return pending_q.size();
		endfunction

		// one level of the walk: follow the entry or allocate a new table
		function logic [STATUS_W-1:0] descend(int unsigned slot, logic [IDX_W-1:0] idx,
				output int unsigned child, inout int unsigned made);
			int unsigned        pos;
			logic [ENTRY_W-1:0] e;
			logic [FRAME_W-1:0] frame;
			logic [FRAME_W-1:0] off;
			pos = slot * ENTRIES + idx;
			e = entry_at(pos);
			child = 0;
			if (!e[0]) begin
				if (next_slot >= SLOTS)
					return ST_EXHAUSTED;
				child = next_slot;
				next_slot++;
				made++;
				frame = base + FRAME_W'(child) - FRAME_W'(1);
				put_entry(pos, {12'h000, frame, FLAGS_DIR});
				return ST_DONE;
			end
			// frame back to slot number; wraps mod 2^40 like the hardware
			off = e[51:12] - base;
			if (64'(off) + 64'd1 >= 64'(next_slot))
				return ST_OUTSIDE;
			child = int'(off) + 1;
			return ST_DONE;
		endfunction

		// accepted request: update the model, queue the expected result
		function logic [STATUS_W-1:0] note_request(logic k, logic [47:0] va, logic [51:0] pa,
				logic [5:0] rs, logic [IDX_W-1:0] re);
			walk_result_t        want;
			int unsigned         made;
			int unsigned         s2;
			int unsigned         s3;
			logic [STATUS_W-1:0] st;
			logic [ENTRY_W-1:0]  leaf;
			made = 0;
			s2 = 0;
			s3 = 0;
			st = ST_DONE;
			want.data = '0;
			if (k == KIND_READ) begin
				n_reads++;
				if (rs < SLOTS)
					want.data = entry_at(rs * ENTRIES + re);
			end else begin
				n_maps++;
				st = descend(0, va[47:39], s2, made);
				if (st == ST_DONE)
					st = descend(s2, va[38:30], s3, made);
				if (st == ST_DONE) begin
					// 2 MiB leaf: phys bits 20..12 dropped
					leaf = {12'h000, pa[51:21], 9'h000, FLAGS_LEAF};
					put_entry(s3 * ENTRIES + va[29:21], leaf);
					want.data = leaf;
				end
			end
			want.status = st;
			want.used = 7'(next_slot);
			want.made = 2'(made);
			st_count[st]++;
			pending_q.push_back(want);
			return st;
		endfunction

		task report(string what, logic [ENTRY_W-1:0] got, logic [ENTRY_W-1:0] want);
			fails++;
			if (fails <= REPORT_CAP)
				$display("%0t: %s mismatch: got 0x%0h, expected 0x%0h", $time, what, got, want);
		endtask

		task check_result(logic [STATUS_W-1:0] st, logic [ENTRY_W-1:0] data,
				logic [6:0] used, logic [1:0] made);
			walk_result_t want;
			if (pending_q.size() == 0) begin
				report("unrequested result, status", st, '0);
				return;
			end
			want = pending_q.pop_front();
			n_checked++;
			if (st !== want.status)
				report("status", st, want.status);
			if (data !== want.data)
				report("read_data", data, want.data);
			if (used !== want.used)
				report("tables_used", used, want.used);
			if (made !== want.made)
				report("new_tables", made, want.made);
		endtask
	endclass

	page_walk_scoreboard sb;
	logic [17:0]         paths [$];   // root/second index pairs built so far
	bit                  no_idle = 1'b0;
	int unsigned         ready_hold = 0;
	int unsigned         idle_cycles = 0;

	// ------------------------------------------------------------------------
	// Result side: random backpressure with occasional long holds
	// ------------------------------------------------------------------------
	always @(posedge clk) begin : stall_gen
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (ready_hold != 0) begin
			out_ready <= 1'b0;
			ready_hold <= ready_hold - 1;
		end else if (no_idle || roll < 70) begin
			out_ready <= 1'b1;
		end else if (roll < 93) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b0;
			ready_hold <= $urandom_range(5, 25);
		end
	end

	// result monitor; values sampled before the edge updates land
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result(status, read_data, tables_used, new_tables);
	end

	// watchdog: any transfer restarts the count
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// ------------------------------------------------------------------------
	// Driver tasks
	// ------------------------------------------------------------------------
	function automatic int unsigned pick_gap();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (no_idle || roll < 65)
			return 0;
		if (roll < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	// one request transfer, then an optional gap with valid low
	task automatic send_request(input logic k, input logic [47:0] va, input logic [51:0] pa,
			input logic [5:0] rs, input logic [IDX_W-1:0] re);
		int unsigned         gap;
		logic [STATUS_W-1:0] st;
		in_valid <= 1'b1;
		kind <= k;
		virt_addr <= va;
		phys_addr <= pa;
		read_slot <= rs;
		read_entry <= re;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		st = sb.note_request(k, va, pa, rs, re);
		if (k == KIND_MAP && st == ST_DONE && sb.pending_q[$].made != 0)
			paths.push_back(va[47:30]);
		gap = pick_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// drop valid and wait for every outstanding result, then let the walk settle
	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic write_base(input logic [FRAME_W-1:0] val);
		cfg_valid <= 1'b1;
		table_base_frame <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		sb.set_base(val);
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	// map address: mostly reuse existing paths so walks get past allocation
	function automatic logic [47:0] pick_map_addr();
		logic [47:0] va;
		logic [17:0] p;
		int unsigned roll;
		va = 48'({$urandom, $urandom});
		roll = $urandom_range(0, 99);
		// one slot left: a fresh root takes it, then the second level runs dry
		if (sb.next_slot == SLOTS - 1)
			roll = 0;
		if (paths.size() != 0 && roll >= 15) begin
			p = paths[$urandom_range(0, paths.size() - 1)];
			if (roll < 40)
				va[47:39] = p[17:9];
			else
				va[47:30] = p;
		end
		return va;
	endfunction

	task automatic send_random();
		logic [47:0]      va;
		logic [51:0]      pa;
		logic [5:0]       rs;
		logic [IDX_W-1:0] re;
		int unsigned      pos;
		va = 48'({$urandom, $urandom});
		pa = 52'({$urandom, $urandom});
		rs = 6'($urandom);
		re = IDX_W'($urandom);
		if ($urandom_range(0, 99) < 55) begin
			send_request(KIND_MAP, pick_map_addr(), pa, rs, re);
		end else begin
			// reads mostly target entries the walks have written
			if (sb.written.size() != 0 && $urandom_range(0, 99) < 60) begin
				pos = sb.written[$urandom_range(0, sb.written.size() - 1)];
				rs = 6'(pos / ENTRIES);
				re = IDX_W'(pos % ENTRIES);
			end
			send_request(KIND_READ, va, pa, rs, re);
		end
	endtask

	// ------------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------------
	initial begin : main_seq
		logic [FRAME_W-1:0] phase_base [4];
		sb = new();
		phase_base[0] = '0;
		phase_base[1] = '1;                             // wraps slot frames
		phase_base[2] = FRAME_W'($urandom_range(1, 8)); // old pointers alias
		phase_base[3] = '0;                             // first-phase tables valid again

		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// cfg is always ready; in_ready waits out the store sweep
		write_base('0);

		// directed: empty store, field extremes, leaf alignment, path reuse
		send_request(KIND_READ, '0, '0, 6'd0, 9'd0);
		send_request(KIND_READ, '1, '1, 6'd63, 9'd511);
		send_request(KIND_MAP, '0, '1, '0, '0);
		send_request(KIND_MAP, '1, '0, '1, '1);
		send_request(KIND_MAP, {9'd0, 9'd511, 9'd5, 21'h1f_ffff}, 52'haaaa_aaaa_aaaaa,
			6'h2a, 9'h155);
		send_request(KIND_MAP, 48'h0000_0000_0abc, 52'h5555_5555_55555, 6'h15, 9'h0aa);
		send_request(KIND_READ, '0, '0, 6'd0, 9'd0);
		send_request(KIND_READ, '0, '0, 6'd1, 9'd0);
		send_request(KIND_READ, '0, '0, 6'd2, 9'd0);
		send_request(KIND_READ, '0, '0, 6'd0, 9'd511);
		send_request(KIND_READ, '0, '0, 6'd4, 9'd511);
		send_request(KIND_READ, '0, '0, 6'd5, 9'd5);
		drain();

		// base moved far away: existing root pointers fall outside the pool
		write_base(40'h80_0000_0000);
		send_request(KIND_MAP, '0, '1, '0, '0);
		send_request(KIND_MAP, '1, '1, '0, '0);
		send_request(KIND_MAP, {9'd7, 9'd3, 9'd9, 21'h0}, 52'h1234_5678_9abcd, '0, '0);
		send_request(KIND_READ, '0, '0, 6'd0, 9'd7);
		drain();

		// random phases, each under its own base frame
		for (int ph = 0; ph < 4; ph++) begin
			write_base(phase_base[ph]);
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 64 == 0)
					no_idle = ($urandom_range(0, 3) == 0);
				send_random();
			end
			no_idle = 1'b0;
			drain();
		end

		$display("Checked %0d results: %0d maps, %0d reads; done %0d, pool empty %0d, outside %0d",
			sb.n_checked, sb.n_maps, sb.n_reads, sb.st_count[ST_DONE],
			sb.st_count[ST_EXHAUSTED], sb.st_count[ST_OUTSIDE]);
		$display("Pool slots in use at end: %0d of %0d; base frames zero, all ones, offset %0d",
			sb.next_slot, SLOTS, phase_base[2]);
		if (sb.fails == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

[page_table_builder_unit.f]
rtl/ptb_pkg.sv
rtl/ptb_table_mem.sv
rtl/ptb_addsub.sv
rtl/page_table_builder_unit.sv
sim/page_table_builder_unit_test.sv
